// ----- src/slv_pkg.sv -----
package slv_pkg;

    // Result item kinds
    localparam logic KIND_SLOT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Pre-render line number that stands for line -1
    localparam logic [8:0] PRE_RENDER_LINE = 9'd261;

    // Sprite heights in rows
    localparam logic [4:0] HEIGHT_SHORT = 5'd8;
    localparam logic [4:0] HEIGHT_TALL  = 5'd16;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // One result item
    typedef struct packed {
        logic       result_kind;
        logic [2:0] slot_number;
        logic [7:0] tile_out;
        logic [7:0] x_out;
        logic [2:0] palette_priority;
        logic [7:0] slot_flags;
        logic [2:0] tile_row;
        logic       overflow;
        logic [3:0] found_count;
        logic       last_result;
    } result_t;

    // Results of one input item: up to two, first one in res0
    typedef struct packed {
        logic [1:0] push_count;
        result_t    res0;
        result_t    res1;
    } eval_out_t;

endpackage

// ----- src/slv_eval.sv -----
module slv_eval #(
    parameter int SLOTS_PER_LINE = 8,
    parameter int SPRITE_ENTRIES = 64,
    parameter int CNT_W          = 4
) (
    input  logic [5:0]           sprite_index,
    input  logic [8:0]           scanline,
    input  logic [7:0]           sprite_y,
    input  logic [7:0]           sprite_tile,
    input  logic [7:0]           sprite_attr,
    input  logic [7:0]           sprite_x,
    input  logic                 zero_hit_seen,
    input  logic                 tall_sprites,
    input  logic [CNT_W-1:0]     slots_filled,
    input  logic                 line_closed,
    output slv_pkg::eval_out_t   eval_out,
    output logic [CNT_W-1:0]     slots_filled_next,
    output logic                 line_closed_next
);

    logic                   line_start;
    logic                   closed;
    logic [CNT_W-1:0]       base_filled;
    logic signed [10:0]     line_num;
    logic signed [10:0]     row;
    logic [4:0]             height;
    logic                   in_range;
    logic                   last_entry;
    logic                   slots_full;
    logic                   slot_hit;
    logic                   no_slot;
    logic                   summary;
    logic [CNT_W-1:0]       filled_after;
    logic                   lower_half;
    logic [2:0]             tile_row;
    slv_pkg::result_t       slot_res;
    slv_pkg::result_t       sum_res;

    // Index 0 opens a fresh line
    assign line_start  = (sprite_index == 6'd0);
    assign closed      = line_start ? 1'b0 : line_closed;
    assign base_filled = line_start ? '0 : slots_filled;

    // Range check against the line being prepared
    assign line_num = (scanline == slv_pkg::PRE_RENDER_LINE) ? -11'sd1
                                                             : $signed({2'b00, scanline});
    assign row      = line_num - $signed({3'b000, sprite_y});
    assign height   = tall_sprites ? slv_pkg::HEIGHT_TALL : slv_pkg::HEIGHT_SHORT;
    assign in_range = (row >= 11'sd0) && (row < $signed({6'b0, height}));

    assign last_entry = (32'(sprite_index) == SPRITE_ENTRIES - 1);
    assign slots_full = (32'(base_filled) >= SLOTS_PER_LINE);

    assign slot_hit = !closed && in_range && !slots_full;
    assign no_slot  = !closed && in_range && slots_full;
    assign summary  = !closed && (no_slot || last_entry);

    assign filled_after = base_filled + CNT_W'(slot_hit);

    // Row within the 8-row tile, lower half only exists for tall sprites
    assign lower_half = row[3];
    assign tile_row   = row[2:0] ^ {3{sprite_attr[7]}};

    // Slot result
    always_comb
    begin
        slot_res                  = '0;
        slot_res.result_kind      = slv_pkg::KIND_SLOT;
        slot_res.slot_number      = 3'(base_filled);
        slot_res.tile_out         = sprite_tile;
        slot_res.x_out            = sprite_x;
        slot_res.palette_priority = {sprite_attr[5], sprite_attr[1:0]};
        slot_res.slot_flags       = {sprite_attr[7:6], lower_half, 3'b000,
                                     line_start && !zero_hit_seen, 1'b1};
        slot_res.tile_row         = tile_row;
        slot_res.overflow         = 1'b0;
        slot_res.found_count      = 4'(filled_after);
        slot_res.last_result      = !last_entry;
    end

    // End of line summary
    always_comb
    begin
        sum_res             = '0;
        sum_res.result_kind = slv_pkg::KIND_SUMMARY;
        sum_res.overflow    = no_slot;
        sum_res.found_count = 4'(filled_after);
        sum_res.last_result = 1'b1;
    end

    // Order results: slot first, summary after it
    always_comb
    begin
        eval_out.push_count = {1'b0, slot_hit} + {1'b0, summary};
        eval_out.res0       = slot_hit ? slot_res : sum_res;
        eval_out.res1       = sum_res;
    end

    assign slots_filled_next = filled_after;
    assign line_closed_next  = closed || summary;

endmodule

// ----- src/slv_result_queue.sv -----
module slv_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  slv_pkg::result_t  din0,
    input  slv_pkg::result_t  din1,
    input  logic              pop,
    output logic              almost_full,
    output logic              not_empty,
    output slv_pkg::result_t  dout
);

    slv_pkg::result_t                 mem_reg [slv_pkg::QUEUE_DEPTH];
    logic [slv_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [slv_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [slv_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [slv_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [slv_pkg::QUEUE_CW-1:0]     count_reg;
    logic [slv_pkg::QUEUE_CW-1:0]     count_next;
    logic [slv_pkg::QUEUE_AW-1:0]     wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + slv_pkg::QUEUE_AW'(1);

    // Store up to two items per cycle
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= din0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= din1;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + slv_pkg::QUEUE_AW'(push_count);
        rd_ptr_next = rd_ptr_reg + slv_pkg::QUEUE_AW'(pop);
        count_next  = count_reg + slv_pkg::QUEUE_CW'(push_count)
                      - slv_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Room for two more items is needed before taking another input
    assign almost_full = (32'(count_reg) > slv_pkg::QUEUE_DEPTH - 2);
    assign not_empty   = (count_reg != '0);
    assign dout        = mem_reg[rd_ptr_reg];

    // Occupancy never exceeds the storage
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= slv_pkg::QUEUE_DEPTH)
        else $error("result queue occupancy beyond depth");

    // No push while the queue lacks room for it
    assert property (@(posedge clk) disable iff (!rst_n)
        almost_full |-> (push_count == 2'd0))
        else $error("push into a full result queue");

    // No pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty result queue");

    // Occupancy holds steady when there is neither push nor pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("result queue occupancy changed without traffic");

endmodule

// ----- src/sprite_line_evaluator.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    sprite_index .. zero_hit_seen
// out       output     out_valid / out_stall  result_kind .. last_result
// cfg       input      cfg_wr_en              cfg_wr_data (tall_sprites)
//
// An input item is evaluated in the cycle it is accepted; its results
// are written to the result queue, which hands them out one per cycle
// while out_stall is low. One item is taken per cycle while in_stall is
// low; an item that ends a line with a slot result gives two results.
// in_stall rises while fewer than two of the four result queue entries are
// free. Reset empties the queue, clears the line state and selects 8x8 sprites.
module sprite_line_evaluator #(
    parameter int SLOTS_PER_LINE = 8,
    parameter int SPRITE_ENTRIES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [5:0] sprite_index,
    input  logic [8:0] scanline,
    input  logic [7:0] sprite_y,
    input  logic [7:0] sprite_tile,
    input  logic [7:0] sprite_attr,
    input  logic [7:0] sprite_x,
    input  logic       zero_hit_seen,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       result_kind,
    output logic [2:0] slot_number,
    output logic [7:0] tile_out,
    output logic [7:0] x_out,
    output logic [2:0] palette_priority,
    output logic [7:0] slot_flags,
    output logic [2:0] tile_row,
    output logic       overflow,
    output logic [3:0] found_count,
    output logic       last_result
);

    localparam int CNT_W = $clog2(SLOTS_PER_LINE + 1);

    logic               tall_sprites_reg;
    logic [CNT_W-1:0]   slots_filled_reg;
    logic [CNT_W-1:0]   slots_filled_next;
    logic               line_closed_reg;
    logic               line_closed_next;
    logic               in_accept;
    logic               out_accept;
    logic               almost_full;
    logic [1:0]         push_count;
    slv_pkg::eval_out_t eval_out;
    slv_pkg::result_t   dout;

    assign in_stall   = almost_full;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_sprites_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            tall_sprites_reg <= cfg_wr_data;
        end
    end

    slv_eval #(
        .SLOTS_PER_LINE (SLOTS_PER_LINE),
        .SPRITE_ENTRIES (SPRITE_ENTRIES),
        .CNT_W          (CNT_W)
    ) u_eval (
        .sprite_index      (sprite_index),
        .scanline          (scanline),
        .sprite_y          (sprite_y),
        .sprite_tile       (sprite_tile),
        .sprite_attr       (sprite_attr),
        .sprite_x          (sprite_x),
        .zero_hit_seen     (zero_hit_seen),
        .tall_sprites      (tall_sprites_reg),
        .slots_filled      (slots_filled_reg),
        .line_closed       (line_closed_reg),
        .eval_out          (eval_out),
        .slots_filled_next (slots_filled_next),
        .line_closed_next  (line_closed_next)
    );

    // Update line state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_filled_reg <= '0;
            line_closed_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            slots_filled_reg <= slots_filled_next;
            line_closed_reg  <= line_closed_next;
        end
    end

    assign push_count = in_accept ? eval_out.push_count : 2'd0;

    slv_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .din0        (eval_out.res0),
        .din1        (eval_out.res1),
        .pop         (out_accept),
        .almost_full (almost_full),
        .not_empty   (out_valid),
        .dout        (dout)
    );

    // Drive result fields from the queue head
    assign result_kind      = dout.result_kind;
    assign slot_number      = dout.slot_number;
    assign tile_out         = dout.tile_out;
    assign x_out            = dout.x_out;
    assign palette_priority = dout.palette_priority;
    assign slot_flags       = dout.slot_flags;
    assign tile_row         = dout.tile_row;
    assign overflow         = dout.overflow;
    assign found_count      = dout.found_count;
    assign last_result      = dout.last_result;

    // Slot count never runs past the slots of a line
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(slots_filled_reg) <= SLOTS_PER_LINE)
        else $error("slot count beyond slots per line");

    // A closed line takes no more slots until index 0 comes
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_closed_reg && in_accept && sprite_index != 6'd0)
        |=> $stable(slots_filled_reg) && line_closed_reg)
        else $error("closed line changed without a line start");

    // A summary result is always the last of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == slv_pkg::KIND_SUMMARY) |-> last_result)
        else $error("summary result not marked last");

endmodule
